// ----- hdl/swmf_pkg.sv -----
// Shared types and constants of the sliding window median filter unit.
package swmf_pkg;

	// Field widths of the pixel stream, result stream and configuration port
	localparam int unsigned PIX_W    = 8;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned COL_W    = 10;
	localparam int unsigned IMG_W_W  = 11;
	localparam int unsigned IMG_H_W  = 12;
	localparam int unsigned CFG_W    = 12;
	localparam int unsigned CFG_IDX_W = 1;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Reset frame size
	localparam int unsigned RST_IMAGE_WIDTH  = 640;
	localparam int unsigned RST_IMAGE_HEIGHT = 480;

	// Position and frame tag that travel with a pixel through the sorter
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} meta_t;

endpackage

// ----- hdl/sliding_window_median_filter_unit.sv -----
// Streaming WINDOW x WINDOW median filter with line store and sorting pipeline.
//
// channel  direction  handshake             payload
// -------  ---------  --------------------  ---------------------------------------
// input    in         in_valid / in_ready   pixel
// output   out        out_valid / out_ready median, out_row, out_col, frame_last
// config   in         cfg_we                cfg_index, cfg_data
//
// One pixel is taken every clock unless the pipeline stalls; a result passes s1, s2, the
// sorter and the output register. The line store is one memory word per column, read on
// acceptance and written as the pixel leaves s1; a column returns no sooner than WINDOW
// pixels on, so no forwarding is needed. The median comes out of a WINDOW*WINDOW stage
// odd-even transposition sorter. Reset clears counters, valid bits and the window; the
// line store is not cleared. The pipeline stalls only when a result waits in the output
// register and the last sorter stage holds another one; bubbles keep draining otherwise.
module sliding_window_median_filter_unit #(
	parameter int unsigned WINDOW    = 3,
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// pixel stream
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [swmf_pkg::PIX_W-1:0]           pixel,
	// result stream
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [swmf_pkg::PIX_W-1:0]           median,
	output logic [swmf_pkg::ROW_W-1:0]           out_row,
	output logic [swmf_pkg::COL_W-1:0]           out_col,
	output logic                                 frame_last,
	// register writes
	input  logic                                 cfg_we,
	input  logic [swmf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swmf_pkg::CFG_W-1:0]           cfg_data
);

	localparam int unsigned PIX_W   = swmf_pkg::PIX_W;
	localparam int unsigned ROW_W   = swmf_pkg::ROW_W;
	localparam int unsigned COL_W   = swmf_pkg::COL_W;
	localparam int unsigned TAPS    = WINDOW * WINDOW;
	localparam int unsigned LINES   = WINDOW - 1;
	localparam int unsigned CW      = $clog2(MAX_WIDTH);
	localparam int unsigned EXT_W   = 13;
	localparam int unsigned OFF     = WINDOW - 1 - WINDOW / 2;
	localparam int unsigned MID     = TAPS / 2;
	localparam int unsigned RST_W   = (swmf_pkg::RST_IMAGE_WIDTH < MAX_WIDTH) ?
		swmf_pkg::RST_IMAGE_WIDTH : MAX_WIDTH;
	localparam logic [CW-1:0]    RST_COL_LAST = CW'(RST_W - 1);
	localparam logic [ROW_W-1:0] RST_ROW_LAST = ROW_W'(swmf_pkg::RST_IMAGE_HEIGHT - 1);

	// ------------------------------------------------------------------
	// Frame size registers, kept as last column and last row
	// ------------------------------------------------------------------
	logic [CW-1:0]    col_last_q;
	logic [ROW_W-1:0] row_last_q;
	logic [EXT_W-1:0] w_ext;
	logic [EXT_W-1:0] w_eff;
	logic [ROW_W-1:0] h_raw;
	logic [ROW_W-1:0] h_eff;

	// Clamp the width to WINDOW..MAX_WIDTH and raise the height to WINDOW
	always_comb begin
		w_ext = EXT_W'(cfg_data[swmf_pkg::IMG_W_W-1:0]);
		if (w_ext < EXT_W'(WINDOW)) begin
			w_eff = EXT_W'(WINDOW);
		end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
			w_eff = EXT_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_raw = cfg_data[swmf_pkg::IMG_H_W-1:0];
		h_eff = (h_raw < ROW_W'(WINDOW)) ? ROW_W'(WINDOW) : h_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= RST_COL_LAST;
			row_last_q <= RST_ROW_LAST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swmf_pkg::REG_IMAGE_WIDTH: begin
					col_last_q <= CW'(w_eff - EXT_W'(1));
				end
				swmf_pkg::REG_IMAGE_HEIGHT: begin
					row_last_q <= h_eff - ROW_W'(1);
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: stall everything only when the output is blocked
	// ------------------------------------------------------------------
	logic            adv;
	logic            in_fire;
	logic [TAPS-1:0] vld_sp;
	logic            out_valid_q;

	assign adv      = !(vld_sp[TAPS-1] && out_valid_q && !out_ready);
	assign in_ready = adv;
	assign in_fire  = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Raster counters and accept stage (s1)
	// ------------------------------------------------------------------
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;
	logic               vld_s1;
	logic               emit_s1;
	logic [PIX_W-1:0]   px_s1;
	logic [CW-1:0]      col_s1;
	swmf_pkg::meta_t    meta_s1;
	logic [CW-1:0]      ocol_full;
	logic               emit_d;
	logic               last_d;

	always_comb begin
		emit_d    = (row_q >= ROW_W'(WINDOW - 1)) && (col_q >= CW'(WINDOW - 1));
		last_d    = (row_q >= row_last_q) && (col_q >= col_last_q);
		ocol_full = col_q - CW'(OFF);
	end

	// Advance the column, wrap to the next line and the next frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			vld_s1  <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_fire;
			emit_s1 <= in_fire && emit_d;
			if (in_fire) begin
				if (col_q >= col_last_q) begin
					col_q <= '0;
					row_q <= (row_q >= row_last_q) ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1         <= pixel;
			col_s1        <= col_q;
			meta_s1.row   <= row_q - ROW_W'(OFF);
			meta_s1.col   <= COL_W'(ocol_full);
			meta_s1.last  <= last_d;
		end
	end

	// ------------------------------------------------------------------
	// Line store: one word of LINES pixels per column, oldest line low
	// ------------------------------------------------------------------
	logic [LINES*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [LINES*PIX_W-1:0] line_rd_q;
	logic [LINES*PIX_W-1:0] line_wr;
	logic [PIX_W-1:0]       new_col [WINDOW];

	// Shift the column up by one line and append the new pixel
	always_comb begin
		for (int a = 0; a < LINES - 1; a++) begin
			line_wr[a*PIX_W +: PIX_W] = line_rd_q[(a+1)*PIX_W +: PIX_W];
		end
		line_wr[(LINES-1)*PIX_W +: PIX_W] = px_s1;
		for (int a = 0; a < LINES; a++) begin
			new_col[a] = line_rd_q[a*PIX_W +: PIX_W];
		end
		new_col[WINDOW-1] = px_s1;
	end

	// Read on acceptance, write back when the pixel leaves s1
	always_ff @(posedge clk) begin
		if (in_fire) begin
			line_rd_q <= line_mem[col_q];
		end
		if (adv && vld_s1) begin
			line_mem[col_s1] <= line_wr;
		end
	end

	// ------------------------------------------------------------------
	// Window registers (s2): shift left, insert the new column
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] window_q [TAPS];
	logic             vld_s2;
	swmf_pkg::meta_t  meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				window_q[i] <= '0;
			end
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1 && emit_s1;
			if (vld_s1) begin
				for (int a = 0; a < WINDOW; a++) begin
					for (int b = 0; b < WINDOW - 1; b++) begin
						window_q[a*WINDOW+b] <= window_q[a*WINDOW+b+1];
					end
					window_q[a*WINDOW+WINDOW-1] <= new_col[a];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			meta_s2 <= meta_s1;
		end
	end

	// ------------------------------------------------------------------
	// Sorter: one odd-even transposition pass per stage
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] key_sp [TAPS][TAPS];
	logic [PIX_W-1:0] key_d  [TAPS][TAPS];
	swmf_pkg::meta_t  meta_sp [TAPS];

	// Compare and exchange disjoint neighbor pairs, even or odd offset by pass
	always_comb begin
		logic [PIX_W-1:0] t;
		t = '0;
		for (int i = 0; i < TAPS; i++) begin
			key_d[0][i] = window_q[i];
		end
		for (int p = 1; p < TAPS; p++) begin
			key_d[p] = key_sp[p-1];
		end
		for (int p = 0; p < TAPS; p++) begin
			for (int i = p & 1; i + 1 < TAPS; i += 2) begin
				if (key_d[p][i] > key_d[p][i+1]) begin
					t              = key_d[p][i];
					key_d[p][i]    = key_d[p][i+1];
					key_d[p][i+1]  = t;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sp <= '0;
		end else if (adv) begin
			vld_sp <= {vld_sp[TAPS-2:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_sp     <= key_d;
			meta_sp[0] <= meta_s2;
			for (int p = 1; p < TAPS; p++) begin
				meta_sp[p] <= meta_sp[p-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] median_q;
	swmf_pkg::meta_t  meta_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && vld_sp[TAPS-1]) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_sp[TAPS-1]) begin
			median_q   <= key_sp[TAPS-1][MID];
			meta_out_q <= meta_sp[TAPS-1];
		end
	end

	assign out_valid  = out_valid_q;
	assign median     = median_q;
	assign out_row    = meta_out_q.row;
	assign out_col    = meta_out_q.col;
	assign frame_last = meta_out_q.last;

`ifndef SYNTHESIS
	// A stall only happens with a result held at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a blocked result");

	// Write-back never hits the column being read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && adv && vld_s1) |-> (col_q != col_s1))
		else $error("line store read and write collide");

	// A pixel in s1 was accepted in the previous cycle or was held there
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ($past(in_fire) || $past(vld_s1 && !adv)))
		else $error("s1 valid without an accepted pixel");

	// The output register drops a result only after it was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without transaction");
`endif

endmodule
